### design/cfqd_pkg.sv
// shared types, constants and helpers for the captured frame queue dumper
// no dependencies; imported by cfqd_ctrl, cfqd_dpath and the top level
package cfqd_pkg;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  // register index of binary_mode, taken from the word address bit
  localparam logic REG_BINARY_MODE = 1'b0;

  // output characters
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;

  // input item kinds
  localparam logic KIND_RX    = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic rx_take;   // store a received byte this cycle
    logic dr_load;   // build the character queue from read data
    logic dr_shift;  // one character taken by the sink
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;     // no committed frame in the ring
    logic one_left;  // last queued character at the output
  } dp_stat_t;

  // uppercase ascii hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = CH_A + {4'd0, v - 4'd10};
    end
    return d;
  endfunction

endpackage

### design/cfqd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module cfqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/cfqd_ctrl.sv
// controller state machine: input acceptance, drain sequencing, output valid
// depends on cfqd_pkg
module cfqd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cfqd_pkg::dp_stat_t stat_i,
  output cfqd_pkg::dp_cmd_t  cmd_o
);
  import cfqd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_DRAIN && !stat_i.empty) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && stat_i.one_left) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    cmd_o.rx_take  = 1'b0;
    cmd_o.dr_load  = 1'b0;
    cmd_o.dr_shift = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd_o.rx_take = in_valid && in_kind == KIND_RX;
      end
      ST_LOAD: begin
        cmd_o.dr_load = 1'b1;
      end
      ST_EMIT: begin
        out_valid      = 1'b1;
        cmd_o.dr_shift = !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/cfqd_dpath.sv
// datapath: frame ring pointers, frame and length memories, character queue
// depends on cfqd_pkg and cfqd_ram
module cfqd_dpath #(
  parameter int SLOTS       = 16,
  parameter int MAX_PAYLOAD = 127
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfqd_pkg::dp_cmd_t  cmd_i,
  input  logic               binary_mode_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               rx_last_i,
  output cfqd_pkg::dp_stat_t stat_o,
  output logic [7:0]         out_char_o
);
  import cfqd_pkg::*;

  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int STORE_DEPTH = SLOTS * MAX_PAYLOAD;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(MAX_PAYLOAD);
  localparam logic [7:0]        MAX_LEN   = 8'(MAX_PAYLOAD);

  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [ADDR_W-1:0] head_base_r, head_base_nxt, tail_base_r, tail_base_nxt;
  logic [7:0]        rx_count_r, rx_count_nxt;
  logic [7:0]        bytes_sent_r, bytes_sent_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [7:0]        q_r [4];
  logic [7:0]        q_nxt [4];

  logic [SLOT_W-1:0] head_after, tail_after;
  logic              full;
  logic [7:0]        rx_len;
  logic              store_we, commit;
  logic [ADDR_W-1:0] store_waddr, store_raddr;
  logic [7:0]        len_rd, byte_rd;
  logic [7:0]        sent_inc;
  logic              frame_done;

  // ring pointer arithmetic
  assign head_after = (head_r == LAST_SLOT) ? '0 : head_r + SLOT_W'(1);
  assign tail_after = (tail_r == LAST_SLOT) ? '0 : tail_r + SLOT_W'(1);
  assign full       = head_after == tail_r;
  assign stat_o.empty    = head_r == tail_r;
  assign stat_o.one_left = cnt_r == 3'd1;

  // receive side: store while below the payload limit, commit on the last byte if not full and within the limit
  assign rx_len      = (rx_count_r == 8'hFF) ? 8'hFF : rx_count_r + 8'd1;
  assign store_we    = cmd_i.rx_take && rx_count_r < MAX_LEN;
  assign store_waddr = head_base_r + ADDR_W'(rx_count_r);
  assign commit      = cmd_i.rx_take && rx_last_i && !full && rx_len <= MAX_LEN;

  // drain side: read addresses always point at the next byte of the oldest frame
  assign store_raddr = tail_base_r + ADDR_W'(bytes_sent_r);
  assign sent_inc    = bytes_sent_r + 8'd1;
  assign frame_done  = sent_inc >= len_rd;

  cfqd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (rx_byte_i),
    .raddr (store_raddr),
    .rdata (byte_rd)
  );

  cfqd_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_lengths (
    .clk   (clk),
    .we    (commit),
    .waddr (head_r),
    .wdata (rx_len),
    .raddr (tail_r),
    .rdata (len_rd)
  );

  // pointer and counter updates
  always_comb begin
    head_nxt       = head_r;
    head_base_nxt  = head_base_r;
    tail_nxt       = tail_r;
    tail_base_nxt  = tail_base_r;
    rx_count_nxt   = rx_count_r;
    bytes_sent_nxt = bytes_sent_r;
    if (cmd_i.rx_take) begin
      rx_count_nxt = rx_last_i ? 8'd0 : rx_len;
    end
    if (commit) begin
      head_nxt      = head_after;
      head_base_nxt = (head_r == LAST_SLOT) ? '0 : head_base_r + BASE_STEP;
    end
    if (cmd_i.dr_load) begin
      if (frame_done) begin
        tail_nxt       = tail_after;
        tail_base_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_base_r + BASE_STEP;
        bytes_sent_nxt = 8'd0;
      end else begin
        bytes_sent_nxt = sent_inc;
      end
    end
  end

  // character queue: load one tick's characters, shift one per output beat
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < 4; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (cmd_i.dr_load) begin
      q_nxt[2] = CH_CR;
      q_nxt[3] = CH_LF;
      if (binary_mode_i) begin
        if (bytes_sent_r == 8'd0) begin
          q_nxt[0] = len_rd;
          q_nxt[1] = byte_rd;
          cnt_nxt  = 3'd2;
        end else begin
          q_nxt[0] = byte_rd;
          q_nxt[1] = byte_rd;
          cnt_nxt  = 3'd1;
        end
      end else begin
        q_nxt[0] = hex_digit(byte_rd[7:4]);
        q_nxt[1] = hex_digit(byte_rd[3:0]);
        cnt_nxt  = frame_done ? 3'd4 : 3'd2;
      end
    end else if (cmd_i.dr_shift) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      q_nxt[2] = q_r[3];
      cnt_nxt  = cnt_r - 3'd1;
    end
  end

  assign out_char_o = q_r[0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      head_base_r  <= '0;
      tail_r       <= '0;
      tail_base_r  <= '0;
      rx_count_r   <= '0;
      bytes_sent_r <= '0;
      cnt_r        <= '0;
    end else begin
      head_r       <= head_nxt;
      head_base_r  <= head_base_nxt;
      tail_r       <= tail_nxt;
      tail_base_r  <= tail_base_nxt;
      rx_count_r   <= rx_count_nxt;
      bytes_sent_r <= bytes_sent_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

### design/captured_frame_queue_dumper.sv
// top level of the captured frame queue dumper: config register, controller, datapath
// depends on cfqd_pkg, cfqd_ctrl, cfqd_dpath
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------
//   in       | sink      | in_valid / in_stall | in_kind, in_rx_byte, in_rx_last
//   out      | source    | out_valid/out_stall | out_char, out_last
//   cfg      | apb slave | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// a received byte beat and a drain tick on an empty ring complete in the idle state;
// a drain tick with data passes the load state (queue load from the registered memory read)
// and then the emit state, one output character (1 or 2 binary, 2 or 4 hex) per cycle while
// out_stall is low; input stalls from a data drain beat until its last character is taken
// reset clears pointers and counters synchronously; frame memories are not cleared
module captured_frame_queue_dumper #(
  parameter int SLOTS       = 16,
  parameter int MAX_PAYLOAD = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfqd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     binary_mode_r, binary_mode_nxt;
  logic     reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1] == REG_BINARY_MODE;

  always_comb begin
    binary_mode_nxt = binary_mode_r;
    if (psel && penable && pwrite && reg_sel) begin
      binary_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r <= 1'b0;
    end else begin
      binary_mode_r <= binary_mode_nxt;
    end
  end

  assign prdata = reg_sel ? {{(PDATA_W-1){1'b0}}, binary_mode_r} : '0;

  cfqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  cfqd_dpath #(.SLOTS(SLOTS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .binary_mode_i (binary_mode_r),
    .rx_byte_i     (in_rx_byte),
    .rx_last_i     (in_rx_last),
    .stat_o        (stat),
    .out_char_o    (out_char)
  );

  assign out_last = stat.one_left;

  // no new beat is taken while characters are pending
  a_stall_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while output pending");

  // a drain beat on a non-empty ring shows a character once the load state has passed
  a_drain_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind == KIND_DRAIN && !stat.empty) |=> ##1 out_valid)
    else $error("drain beat produced no output");

  // a received byte beat produces no output
  a_rx_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_kind == KIND_RX) |=> !out_valid)
    else $error("received byte produced output");

  // the last character ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("output continued after last character");

endmodule
